// ===== rtl/uvs_pkg.sv =====
// ----------------------------------------------------------------------------
// uvs_pkg
// shared types and codes for the unique value stack
// ----------------------------------------------------------------------------
package uvs_pkg;

  // item kinds
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  // cells per group in the match reduction tree
  localparam int GROUP_SIZE = 8;

  // shift control broadcast to every cell
  typedef struct packed {
    logic push;  // shift toward higher index, cell 0 takes the new value
    logic pop;   // shift toward lower index, newest entry drops out
  } uvs_shift_t;

endpackage

// ===== rtl/uvs_cell.sv =====
// ----------------------------------------------------------------------------
// uvs_cell
// one storage cell: holds an entry, shifts with its neighbors, compares
// ----------------------------------------------------------------------------
module uvs_cell import uvs_pkg::*; #(
  parameter int VALUE_BITS = 16
) (
  input  logic                  clk,
  input  uvs_shift_t            shift,
  input  logic                  occupied,
  input  logic [VALUE_BITS-1:0] left_val,
  input  logic [VALUE_BITS-1:0] right_val,
  input  logic                  cmp_en,
  input  logic [VALUE_BITS-1:0] cmp_val,
  output logic [VALUE_BITS-1:0] val,
  output logic                  match
);

  logic [VALUE_BITS-1:0] value_r;
  logic                  match_r;

  always_ff @(posedge clk) begin
    if (shift.push) begin
      value_r <= left_val;
    end else if (shift.pop) begin
      value_r <= right_val;
    end
  end

  // hit only counts for an entry that is in the list
  always_ff @(posedge clk) begin
    if (cmp_en) begin
      match_r <= occupied && (value_r == cmp_val);
    end
  end

  assign val   = value_r;
  assign match = match_r;

endmodule

// ===== rtl/uvs_match_tree.sv =====
// ----------------------------------------------------------------------------
// uvs_match_tree
// registered or-reduction of the per-cell hit bits
// ----------------------------------------------------------------------------
module uvs_match_tree import uvs_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  logic                clk,
  input  logic [CAPACITY-1:0] hits,
  output logic                any_hit
);

  localparam int NUM_GROUPS = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;

  logic [NUM_GROUPS-1:0] group_r;
  logic [NUM_GROUPS-1:0] group_nxt;

  always_comb begin
    group_nxt = '0;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      for (int k = 0; k < GROUP_SIZE; k++) begin
        if (g * GROUP_SIZE + k < CAPACITY) begin
          group_nxt[g] = group_nxt[g] | hits[g * GROUP_SIZE + k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    group_r <= group_nxt;
  end

  assign any_hit = |group_r;

endmodule

// ===== rtl/unique_value_stack_core.sv =====
// ----------------------------------------------------------------------------
// unique_value_stack_core
// insertion-ordered list of unique values held in a chain of shift cells
// ----------------------------------------------------------------------------
//
//   channel | direction | ports                                   | handshake
//   --------+-----------+-----------------------------------------+--------------
//   in      | input     | in_kind, in_value                       | in_valid/in_stall
//   out     | output    | out_duplicate, out_overflow,            | out_valid/out_stall
//           |           | out_entry_count, out_is_empty           |
//
// per item: the accepting edge latches the per-cell compares, the next edge
// registers the grouped or of the hits, and the decide edge, once the result
// slot is free, decides, shifts the cell chain and loads the result register
// one item is in flight at a time; in_stall is high from the accepting edge
// until its result is loaded
// a stalled result holds the block in the decide step until the slot frees;
// the next item may be accepted while a loaded result still waits
// reset clears only the entry count and the control state; cells hold no
// valid bits since occupancy follows from the count
//
module unique_value_stack_core import uvs_pkg::*; #(
  parameter int CAPACITY   = 64,
  parameter int VALUE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_kind,
  input  logic [VALUE_BITS-1:0]         in_value,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_duplicate,
  output logic                          out_overflow,
  output logic [$clog2(CAPACITY+1)-1:0] out_entry_count,
  output logic                          out_is_empty
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  // phase codes
  localparam logic [1:0] PH_IDLE   = 2'd0;  // ready for a transfer
  localparam logic [1:0] PH_REDUCE = 2'd1;  // hit bits being or-ed into groups
  localparam logic [1:0] PH_DECIDE = 2'd2;  // apply the item, load the result

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  logic [1:0]            phase_r, phase_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic                  kind_r;
  logic [VALUE_BITS-1:0] value_r;

  logic                  out_valid_r, out_valid_nxt;
  logic                  out_dup_r, out_ovf_r, out_empty_r;
  logic [CNT_W-1:0]      out_count_r;

  logic                  accept;
  logic                  commit;
  logic                  any_hit;
  logic                  dup, ovf;
  uvs_shift_t            shift;

  logic [CAPACITY-1:0]   hits;
  logic [VALUE_BITS-1:0] cell_val [CAPACITY];

  // ---------------------------------------------------------------------------
  // handshake
  // ---------------------------------------------------------------------------
  assign accept   = in_valid && !in_stall;
  assign in_stall = (phase_r != PH_IDLE);

  // decide only when the result register is free or being emptied this cycle
  assign commit = (phase_r == PH_DECIDE) && (!out_valid_r || !out_stall);

  // ---------------------------------------------------------------------------
  // item capture; compare against the new value happens in the cells
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r  <= in_kind;
      value_r <= in_value;
    end
  end

  // ---------------------------------------------------------------------------
  // cell chain: cell 0 holds the newest entry
  // ---------------------------------------------------------------------------
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam logic [CNT_W-1:0] IDX = CNT_W'(i);
    logic [VALUE_BITS-1:0] left_val;
    logic [VALUE_BITS-1:0] right_val;

    if (i == 0) begin : g_head
      assign left_val = value_r;
    end else begin : g_body
      assign left_val = cell_val[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_val = '0;
    end else begin : g_link
      assign right_val = cell_val[i+1];
    end

    uvs_cell #(
      .VALUE_BITS (VALUE_BITS)
    ) u_cell (
      .clk       (clk),
      .shift     (shift),
      .occupied  (IDX < count_r),
      .left_val  (left_val),
      .right_val (right_val),
      .cmp_en    (accept),
      .cmp_val   (in_value),
      .val       (cell_val[i]),
      .match     (hits[i])
    );
  end

  // ---------------------------------------------------------------------------
  // hit reduction, one register stage of groups
  // ---------------------------------------------------------------------------
  uvs_match_tree #(
    .CAPACITY (CAPACITY)
  ) u_match_tree (
    .clk     (clk),
    .hits    (hits),
    .any_hit (any_hit)
  );

  // ---------------------------------------------------------------------------
  // decide: duplicate test before full test, remove on empty does nothing
  // ---------------------------------------------------------------------------
  always_comb begin
    dup        = 1'b0;
    ovf        = 1'b0;
    shift.push = 1'b0;
    shift.pop  = 1'b0;
    count_nxt  = count_r;
    if (commit) begin
      unique case (kind_r)
        KIND_INSERT: begin
          priority if (any_hit) begin
            dup = 1'b1;
          end else if (count_r == CAP_CNT) begin
            ovf = 1'b1;
          end else begin
            shift.push = 1'b1;
            count_nxt  = count_r + CNT_W'(1);
          end
        end
        KIND_REMOVE: begin
          if (count_r != '0) begin
            shift.pop = 1'b1;
            count_nxt = count_r - CNT_W'(1);
          end
        end
        default: begin
          count_nxt = count_r;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // phase sequencing
  // ---------------------------------------------------------------------------
  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      PH_IDLE:   if (accept) phase_nxt = PH_REDUCE;
      PH_REDUCE: phase_nxt = PH_DECIDE;
      PH_DECIDE: if (commit) phase_nxt = PH_IDLE;
      default:   phase_nxt = PH_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result register, loaded on the decide step
  always_ff @(posedge clk) begin
    if (commit) begin
      out_dup_r   <= dup;
      out_ovf_r   <= ovf;
      out_count_r <= count_nxt;
      out_empty_r <= (count_nxt == '0);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_duplicate   = out_dup_r;
  assign out_overflow    = out_ovf_r;
  assign out_entry_count = out_count_r;
  assign out_is_empty    = out_empty_r;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_CNT)
    else $error("entry count above capacity");

  a_shift_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(shift.push && shift.pop))
    else $error("push and pop in the same cycle");

  a_accept_seq: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (phase_r == PH_REDUCE) ##1 (phase_r == PH_DECIDE))
    else $error("item did not walk through reduce and decide");

  a_commit_out: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> out_valid && (out_is_empty == (out_entry_count == '0)))
    else $error("result not presented after decide");

endmodule
